@@ src/tun_pkg.sv @@
package tun_pkg;

	localparam int COORD_BITS = 12;
	localparam int FRAC_OUT   = 14;
	localparam int OUT_W      = 16;
	localparam int EDGE_W     = COORD_BITS + 1;
	localparam int PROD_W     = 2 * EDGE_W;
	localparam int CROSS_W    = PROD_W + 1;
	localparam int MAG_W      = 2 * COORD_BITS + 1;
	localparam int SQ_W       = 2 * MAG_W;
	localparam int LEN_W      = SQ_W + 2;
	localparam int Q_W        = FRAC_OUT + 1;
	localparam int WIDE_W     = LEN_W + 2 * Q_W + 2;
	localparam int N_CELLS    = Q_W;
	localparam int BIT_W      = $clog2(Q_W);

	typedef struct packed {
		logic [LEN_W-1:0]            len2;
		logic                        deg;
		logic [2:0]                  sgn;
		logic [2:0][WIDE_W-1:0]      rem;
		logic [2:0][WIDE_W-1:0]      ql;
		logic [2:0][Q_W-1:0]         q;
	} cell_data_t;

endpackage

@@ src/triangle_unit_normal_unit.sv @@
// Pipeline: 5 front stages, 15 root cells, then the output register.
// Throughput: one item per cycle when not stalled; each cell resolves one quotient bit for all three axes.
// Every stage has its own valid, so bubbles close up under output stall.
// Reset (arst_n, async, active low) clears valid bits only; no data state.
module triangle_unit_normal_unit (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic signed [tun_pkg::COORD_BITS-1:0] a_x,
	input  logic signed [tun_pkg::COORD_BITS-1:0] a_y,
	input  logic signed [tun_pkg::COORD_BITS-1:0] a_z,
	input  logic signed [tun_pkg::COORD_BITS-1:0] b_x,
	input  logic signed [tun_pkg::COORD_BITS-1:0] b_y,
	input  logic signed [tun_pkg::COORD_BITS-1:0] b_z,
	input  logic signed [tun_pkg::COORD_BITS-1:0] c_x,
	input  logic signed [tun_pkg::COORD_BITS-1:0] c_y,
	input  logic signed [tun_pkg::COORD_BITS-1:0] c_z,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic signed [tun_pkg::OUT_W-1:0]      norm_x,
	output logic signed [tun_pkg::OUT_W-1:0]      norm_y,
	output logic signed [tun_pkg::OUT_W-1:0]      norm_z,
	output logic                                  degenerate
);

	localparam int NC = tun_pkg::N_CELLS;

	logic [NC:0]               cv;
	logic [NC:0]               cs;
	tun_pkg::cell_data_t [NC:0] cd;

	logic                                  v_q;
	logic                                  rdy;
	logic [2:0][tun_pkg::OUT_W-1:0]        nrm_d;
	logic signed [tun_pkg::OUT_W-1:0]      nx_q, ny_q, nz_q;
	logic                                  deg_q;

	tun_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.a_x      (a_x),
		.a_y      (a_y),
		.a_z      (a_z),
		.b_x      (b_x),
		.b_y      (b_y),
		.b_z      (b_z),
		.c_x      (c_x),
		.c_y      (c_y),
		.c_z      (c_z),
		.out_valid(cv[0]),
		.out_stall(cs[0]),
		.out_data (cd[0])
	);

	for (genvar k = 0; k < NC; k++) begin : g_cell
		tun_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.bit_idx  (tun_pkg::BIT_W'(tun_pkg::FRAC_OUT - k)),
			.in_valid (cv[k]),
			.in_stall (cs[k]),
			.in_data  (cd[k]),
			.out_valid(cv[k+1]),
			.out_stall(cs[k+1]),
			.out_data (cd[k+1])
		);
	end

	assign rdy    = !v_q || !out_stall;
	assign cs[NC] = !rdy;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (cd[NC].deg) begin
				nrm_d[i] = '0;
			end else if (cd[NC].sgn[i]) begin
				nrm_d[i] = '0 - tun_pkg::OUT_W'(cd[NC].q[i]);
			end else begin
				nrm_d[i] = tun_pkg::OUT_W'(cd[NC].q[i]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (rdy) begin
			v_q <= cv[NC];
		end
	end

	always_ff @(posedge clk) begin
		if (rdy && cv[NC]) begin
			nx_q  <= nrm_d[0];
			ny_q  <= nrm_d[1];
			nz_q  <= nrm_d[2];
			deg_q <= cd[NC].deg;
		end
	end

	assign out_valid  = v_q;
	assign norm_x     = nx_q;
	assign norm_y     = ny_q;
	assign norm_z     = nz_q;
	assign degenerate = deg_q;

	a_deg_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && degenerate |-> norm_x == 0 && norm_y == 0 && norm_z == 0)
		else $error("degenerate item with nonzero normal");

	a_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !degenerate |-> norm_x != 0 || norm_y != 0 || norm_z != 0)
		else $error("zero normal on non-degenerate item");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> norm_x <= 16384 && norm_x >= -16384
			&& norm_y <= 16384 && norm_y >= -16384
			&& norm_z <= 16384 && norm_z >= -16384)
		else $error("normal component out of unit range");

	a_cell_flow: assert property (@(posedge clk) disable iff (!arst_n)
		cv[NC] && !cs[NC] |=> out_valid)
		else $error("item lost between last cell and output");

endmodule

@@ src/tun_front.sv @@
module tun_front (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic signed [tun_pkg::COORD_BITS-1:0] a_x,
	input  logic signed [tun_pkg::COORD_BITS-1:0] a_y,
	input  logic signed [tun_pkg::COORD_BITS-1:0] a_z,
	input  logic signed [tun_pkg::COORD_BITS-1:0] b_x,
	input  logic signed [tun_pkg::COORD_BITS-1:0] b_y,
	input  logic signed [tun_pkg::COORD_BITS-1:0] b_z,
	input  logic signed [tun_pkg::COORD_BITS-1:0] c_x,
	input  logic signed [tun_pkg::COORD_BITS-1:0] c_y,
	input  logic signed [tun_pkg::COORD_BITS-1:0] c_z,
	output logic                                out_valid,
	input  logic                                out_stall,
	output tun_pkg::cell_data_t                 out_data
);

	localparam int NST = 5;

	logic [NST-1:0] v_q;
	logic [NST:0]   rdy;

	logic signed [2:0][tun_pkg::EDGE_W-1:0]  e1_s1, e2_s1;
	logic signed [5:0][tun_pkg::PROD_W-1:0]  p_s2;
	logic signed [2:0][tun_pkg::CROSS_W-1:0] n_s3;
	logic [2:0]                              sgn_s4;
	logic [2:0][tun_pkg::SQ_W-1:0]           sq_s4;
	tun_pkg::cell_data_t                     d_s5;

	logic signed [2:0][tun_pkg::EDGE_W-1:0]    e1_d, e2_d;
	logic signed [5:0][tun_pkg::PROD_W-1:0]    p_d;
	logic signed [2:0][tun_pkg::CROSS_W-1:0]   n_d;
	logic [2:0][tun_pkg::SQ_W-1:0]             sq_d;
	logic [tun_pkg::LEN_W-1:0]                 len_d;
	tun_pkg::cell_data_t                       d_d;
	logic signed [2*tun_pkg::CROSS_W-1:0]      sqf;

	always_comb begin
		rdy[NST] = !out_stall;
		for (int k = NST - 1; k >= 0; k--) begin
			rdy[k] = !v_q[k] || rdy[k+1];
		end
	end

	assign in_stall  = !rdy[0];
	assign out_valid = v_q[NST-1];
	assign out_data  = d_s5;

	always_comb begin
		e1_d[0] = tun_pkg::EDGE_W'(b_x) - tun_pkg::EDGE_W'(a_x);
		e1_d[1] = tun_pkg::EDGE_W'(b_y) - tun_pkg::EDGE_W'(a_y);
		e1_d[2] = tun_pkg::EDGE_W'(b_z) - tun_pkg::EDGE_W'(a_z);
		e2_d[0] = tun_pkg::EDGE_W'(c_x) - tun_pkg::EDGE_W'(a_x);
		e2_d[1] = tun_pkg::EDGE_W'(c_y) - tun_pkg::EDGE_W'(a_y);
		e2_d[2] = tun_pkg::EDGE_W'(c_z) - tun_pkg::EDGE_W'(a_z);
		p_d[0] = $signed(e2_s1[1]) * $signed(e1_s1[2]);
		p_d[1] = $signed(e2_s1[2]) * $signed(e1_s1[1]);
		p_d[2] = $signed(e2_s1[2]) * $signed(e1_s1[0]);
		p_d[3] = $signed(e2_s1[0]) * $signed(e1_s1[2]);
		p_d[4] = $signed(e2_s1[0]) * $signed(e1_s1[1]);
		p_d[5] = $signed(e2_s1[1]) * $signed(e1_s1[0]);
		for (int i = 0; i < 3; i++) begin
			n_d[i] = tun_pkg::CROSS_W'($signed(p_s2[2*i]))
				- tun_pkg::CROSS_W'($signed(p_s2[2*i+1]));
		end
		sqf = '0;
		for (int i = 0; i < 3; i++) begin
			sqf     = $signed(n_s3[i]) * $signed(n_s3[i]);
			sq_d[i] = sqf[tun_pkg::SQ_W-1:0];
		end
		len_d = tun_pkg::LEN_W'(sq_s4[0]) + tun_pkg::LEN_W'(sq_s4[1])
			+ tun_pkg::LEN_W'(sq_s4[2]);
		d_d.len2 = len_d;
		d_d.deg  = (len_d == '0);
		d_d.sgn  = sgn_s4;
		for (int i = 0; i < 3; i++) begin
			d_d.rem[i] = tun_pkg::WIDE_W'(sq_s4[i]) << (2 * tun_pkg::FRAC_OUT);
			d_d.ql[i]  = '0;
			d_d.q[i]   = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			if (rdy[0]) v_q[0] <= in_valid;
			for (int k = 1; k < NST; k++) begin
				if (rdy[k]) v_q[k] <= v_q[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy[0] && in_valid) begin
			e1_s1 <= e1_d;
			e2_s1 <= e2_d;
		end
		if (rdy[1] && v_q[0]) p_s2 <= p_d;
		if (rdy[2] && v_q[1]) n_s3 <= n_d;
		if (rdy[3] && v_q[2]) begin
			sq_s4 <= sq_d;
			for (int i = 0; i < 3; i++) sgn_s4[i] <= n_s3[i][tun_pkg::CROSS_W-1];
		end
		if (rdy[4] && v_q[3]) d_s5 <= d_d;
	end

endmodule

@@ src/tun_cell.sv @@
module tun_cell (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [tun_pkg::BIT_W-1:0]  bit_idx,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  tun_pkg::cell_data_t        in_data,
	output logic                       out_valid,
	input  logic                       out_stall,
	output tun_pkg::cell_data_t        out_data
);

	logic                 v_q;
	tun_pkg::cell_data_t  d_q;
	tun_pkg::cell_data_t  nx;
	logic                 rdy;
	logic [tun_pkg::WIDE_W-1:0] len_w, trial;

	assign rdy       = !v_q || !out_stall;
	assign in_stall  = !rdy;
	assign out_valid = v_q;
	assign out_data  = d_q;

	// trial ((q + 2^b)^2 - q^2) L against remainder m^2 2^2F - q^2 L
	always_comb begin
		nx    = in_data;
		len_w = tun_pkg::WIDE_W'(in_data.len2);
		trial = '0;
		for (int i = 0; i < 3; i++) begin
			trial = (in_data.ql[i] << ({1'b0, bit_idx} + 1'b1))
				+ (len_w << {bit_idx, 1'b0});
			if (in_data.rem[i] >= trial) begin
				nx.rem[i]        = in_data.rem[i] - trial;
				nx.ql[i]         = in_data.ql[i] + (len_w << bit_idx);
				nx.q[i][bit_idx] = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (rdy) begin
			v_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy && in_valid) d_q <= nx;
	end

endmodule

@@ tb/sv/triangle_unit_normal_unit_test.sv @@
module triangle_unit_normal_unit_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LIMIT = 4000;
	localparam int N_RANDOM = 1880;
	localparam int TAIL = 60;

	typedef logic signed [tun_pkg::COORD_BITS-1:0] coord_t;
	typedef logic signed [tun_pkg::OUT_W-1:0] comp_t;

	typedef struct {
		coord_t v[9];
	} tri_t;

	typedef struct {
		comp_t nx;
		comp_t ny;
		comp_t nz;
		logic  deg;
	} normal_t;

	typedef struct {
		tri_t    t;
		bit      fixed;
		normal_t want;
	} row_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	coord_t a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z;
	logic out_valid;
	logic out_stall;
	comp_t norm_x, norm_y, norm_z;
	logic degenerate;

	triangle_unit_normal_unit dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.a_x(a_x), .a_y(a_y), .a_z(a_z),
		.b_x(b_x), .b_y(b_y), .b_z(b_z),
		.c_x(c_x), .c_y(c_y), .c_z(c_z),
		.out_valid(out_valid), .out_stall(out_stall),
		.norm_x(norm_x), .norm_y(norm_y), .norm_z(norm_z),
		.degenerate(degenerate)
	);

	normal_t pending_normals[$];
	row_t    directed[$];
	int      errors = 0;
	int      idle_cycles = 0;
	bit      quiet = 0;
	bit      hold_rx = 0;
	int      hold_len = 0;

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	// largest q with q^2 * len2 <= m^2 * 2^(2*FRAC_OUT)
	function automatic comp_t unit_axis(longint signed n, logic [127:0] len2);
		logic [127:0] rhs;
		logic [127:0] lhs;
		logic [63:0]  m;
		logic [63:0]  q;
		logic [63:0]  t;
		m = (n < 0) ? -n : n;
		rhs = ({64'd0, m} * {64'd0, m}) << (2 * tun_pkg::FRAC_OUT);
		q = '0;
		for (int b = tun_pkg::FRAC_OUT; b >= 0; b--) begin
			t = q | (64'd1 << b);
			lhs = {64'd0, t * t} * len2;
			if (lhs <= rhs)
				q = t;
		end
		return (n < 0) ? comp_t'(-q) : comp_t'(q);
	endfunction

	function automatic normal_t face_normal(tri_t t);
		longint signed e1[3], e2[3], n[3];
		logic [127:0] len2;
		normal_t r;
		for (int i = 0; i < 3; i++) begin
			e1[i] = longint'(t.v[3+i]) - longint'(t.v[i]);
			e2[i] = longint'(t.v[6+i]) - longint'(t.v[i]);
		end
		n[0] = e2[1] * e1[2] - e2[2] * e1[1];
		n[1] = e2[2] * e1[0] - e2[0] * e1[2];
		n[2] = e2[0] * e1[1] - e2[1] * e1[0];
		len2 = '0;
		for (int i = 0; i < 3; i++)
			len2 += 128'(n[i] * n[i]);
		if (len2 == 0) begin
			r = '{0, 0, 0, 1'b1};
		end else begin
			r.nx = unit_axis(n[0], len2);
			r.ny = unit_axis(n[1], len2);
			r.nz = unit_axis(n[2], len2);
			r.deg = 1'b0;
		end
		return r;
	endfunction

	function automatic tri_t mk(int v0, int v1, int v2, int v3, int v4, int v5,
			int v6, int v7, int v8);
		tri_t t;
		t.v[0] = coord_t'(v0); t.v[1] = coord_t'(v1); t.v[2] = coord_t'(v2);
		t.v[3] = coord_t'(v3); t.v[4] = coord_t'(v4); t.v[5] = coord_t'(v5);
		t.v[6] = coord_t'(v6); t.v[7] = coord_t'(v7); t.v[8] = coord_t'(v8);
		return t;
	endfunction

	function automatic tri_t random_tri();
		tri_t t;
		int mode;
		mode = $urandom_range(0, 9);
		for (int i = 0; i < 9; i++) begin
			case (mode)
				0: t.v[i] = $urandom_range(0, 1) ? coord_t'(-2048) : coord_t'(2047);
				1: t.v[i] = coord_t'($urandom_range(0, 8) - 4);
				default: t.v[i] = coord_t'($urandom);
			endcase
		end
		// collinear or repeated vertices
		if (mode == 2)
			t.v[6:8] = t.v[3:5];
		if (mode == 3)
			for (int i = 0; i < 3; i++)
				t.v[6+i] = coord_t'(t.v[i] + 2 * (t.v[3+i] - t.v[i]));
		return t;
	endfunction

	task automatic gap();
		repeat ($urandom_range(1, 18)) @(negedge clk);
	endtask

	task automatic send(tri_t t);
		{a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z} <=
			{t.v[0], t.v[1], t.v[2], t.v[3], t.v[4], t.v[5], t.v[6], t.v[7], t.v[8]};
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic drive(tri_t t, bit fixed, normal_t want);
		normal_t got;
		got = face_normal(t);
		if (fixed && (got.nx !== want.nx || got.ny !== want.ny
				|| got.nz !== want.nz || got.deg !== want.deg)) begin
			$display("%0t table row disagrees: table %0d %0d %0d %0b predictor %0d %0d %0d %0b",
				$time, want.nx, want.ny, want.nz, want.deg, got.nx, got.ny, got.nz, got.deg);
			errors++;
		end
		pending_normals.insert(pending_normals.size(), fixed ? want : got);
		send(t);
		if (!quiet && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			gap();
		end
	endtask

	always @(posedge clk) begin
		normal_t w;
		if (in_valid && !in_stall || out_valid && !out_stall)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (out_valid && !out_stall) begin
			if (pending_normals.size() == 0) begin
				$display("%0t unexpected result %0d %0d %0d %0b", $time,
					norm_x, norm_y, norm_z, degenerate);
				errors++;
			end else begin
				w = pending_normals.pop_front();
				if (norm_x !== w.nx) begin
					$display("%0t norm_x expected %0d got %0d", $time, w.nx, norm_x);
					errors++;
				end
				if (norm_y !== w.ny) begin
					$display("%0t norm_y expected %0d got %0d", $time, w.ny, norm_y);
					errors++;
				end
				if (norm_z !== w.nz) begin
					$display("%0t norm_z expected %0d got %0d", $time, w.nz, norm_z);
					errors++;
				end
				if (degenerate !== w.deg) begin
					$display("%0t degenerate expected %0b got %0b", $time, w.deg, degenerate);
					errors++;
				end
			end
		end
	end

	// receiver: random stall bursts, one long hold-off on request
	initial begin
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_rx) begin
				out_stall <= 1'b1;
				for (hold_len = 0; hold_len < 200; hold_len++)
					@(negedge clk);
				hold_rx = 0;
				out_stall <= 1'b0;
			end else if (!quiet && $urandom_range(0, 7) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 18)) @(negedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	initial begin
		forever begin
			@(posedge clk);
			if (idle_cycles >= LIMIT) begin
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	initial begin
		tri_t t;
		arst_n = 1'b0;
		in_valid = 1'b0;
		{a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z} = '0;

		// all zero, and a repeated vertex: degenerate
		directed.insert(directed.size(), '{mk(0,0,0, 0,0,0, 0,0,0), 1, '{0, 0, 0, 1}});
		directed.insert(directed.size(), '{mk(5,-7,9, 5,-7,9, 100,3,-2), 1, '{0, 0, 0, 1}});
		// collinear at the extremes
		directed.insert(directed.size(),
			'{mk(-2048,-2048,-2048, 0,0,0, 2047,2047,2047), 0, '{0,0,0,0}});
		// axis-aligned: e1 = x, e2 = y, n = e2 x e1 = -z
		directed.insert(directed.size(), '{mk(0,0,0, 256,0,0, 0,256,0), 1, '{0, 0, -16384, 0}});
		directed.insert(directed.size(), '{mk(0,0,0, 0,256,0, 256,0,0), 1, '{0, 0, 16384, 0}});
		directed.insert(directed.size(), '{mk(0,0,0, 0,1,0, 0,0,1), 1, '{-16384, 0, 0, 0}});
		directed.insert(directed.size(), '{mk(0,0,0, 0,0,1, 1,0,0), 1, '{0, -16384, 0, 0}});
		// largest edges
		directed.insert(directed.size(),
			'{mk(-2048,-2048,-2048, 2047,-2048,-2048, -2048,2047,-2048),
			1, '{0, 0, -16384, 0}});
		directed.insert(directed.size(),
			'{mk(2047,2047,2047, -2048,2047,2047, 2047,-2048,2047),
			1, '{0, 0, -16384, 0}});
		directed.insert(directed.size(),
			'{mk(-2048,2047,-2048, 2047,-2048,2047, 2047,2047,-2048),
			0, '{0,0,0,0}});
		directed.insert(directed.size(),
			'{mk(2047,-2048,2047, -2048,2047,-2048, -2048,-2048,2047),
			0, '{0,0,0,0}});
		directed.insert(directed.size(), '{mk(0,0,0, 1,2,3, -3,1,2), 0, '{0,0,0,0}});
		directed.insert(directed.size(), '{mk(-1,-1,-1, 1,0,0, 0,1,0), 0, '{0,0,0,0}});
		directed.insert(directed.size(), '{mk(1,1,1, -1,-1,1, 1,-1,-1), 0, '{0,0,0,0}});
		directed.insert(directed.size(),
			'{mk(-2048,0,2047, 0,2047,-2048, 2047,-2048,0), 0, '{0,0,0,0}});

		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (directed[i])
			drive(directed[i].t, directed[i].fixed, directed[i].want);

		for (int k = 0; k < N_RANDOM; k++) begin
			if (k == 300) begin
				in_valid <= 1'b0;
				hold_rx = 1;
				wait (hold_len > 0);
			end
			if (k == 700) begin
				in_valid <= 1'b0;
				while (pending_normals.size() != 0)
					@(negedge clk);
				@(negedge clk);
			end
			if (k == N_RANDOM - 250)
				quiet = 1;
			t = random_tri();
			drive(t, 0, '{0,0,0,0});
		end
		in_valid <= 1'b0;
		while (pending_normals.size() != 0)
			@(negedge clk);
		repeat (TAIL) @(posedge clk);
		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end
endmodule
